// File: hdl/ttd_pkg.sv
// Package for the touchpad tap/drag recognizer: payload and config types,
// gesture state codes, register indexes and small compare helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttd_pkg;

  localparam int COORD_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int LIMIT_BITS = 16;
  localparam int COUNT_BITS = 3;
  localparam int LAST_BITS  = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Previous finger count after reset: unknown, counts as fingers down
  localparam logic [LAST_BITS-1:0] COUNT_UNKNOWN = '1;
  localparam logic [COUNT_BITS-1:0] TWO_FINGERS = COUNT_BITS'(2);

  typedef struct packed {
    logic                  finger_present;
    logic [COUNT_BITS-1:0] finger_total;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [TIME_BITS-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic button_held;
    logic right_click_pulse;
    logic double_click_pulse;
  } out_item_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] tap_limit_ms;
    logic [LIMIT_BITS-1:0] double_tap_window_ms;
    logic [LIMIT_BITS-1:0] drag_lock_window_ms;
    logic [LIMIT_BITS-1:0] release_grace_ms;
    logic [COORD_BITS-1:0] move_limit;
    logic [COORD_BITS-1:0] same_spot_limit;
    logic                  drag_lock_on;
  } cfg_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TAP_LIMIT   = 3'd0,
    REG_DOUBLE_WIN  = 3'd1,
    REG_LOCK_WIN    = 3'd2,
    REG_DROP_GRACE  = 3'd3,
    REG_MOVE_LIMIT  = 3'd4,
    REG_SPOT_LIMIT  = 3'd5,
    REG_LOCK_ON     = 3'd6
  } cfg_reg_e;

  typedef enum logic [7:0] {
    MODE_IDLE      = 8'b0000_0001,
    MODE_TOUCH     = 8'b0000_0010,
    MODE_TOUCH2    = 8'b0000_0100,
    MODE_FIRST_TAP = 8'b0000_1000,
    MODE_SECOND    = 8'b0001_0000,
    MODE_DRAG      = 8'b0010_0000,
    MODE_DRAG_WAIT = 8'b0100_0000,
    MODE_DEAD      = 8'b1000_0000
  } mode_e;

  typedef enum logic [1:0] {
    EV_TOUCH   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOTION  = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

  // Wrapping time difference compared against a 16-bit limit
  function automatic logic time_over(input logic [TIME_BITS-1:0] now,
                                     input logic [TIME_BITS-1:0] then,
                                     input logic [LIMIT_BITS-1:0] lim);
    logic [TIME_BITS-1:0] diff;
    diff = now - then;
    return diff > TIME_BITS'(lim);
  endfunction

  // Absolute coordinate distance within a limit
  function automatic logic near(input logic [COORD_BITS-1:0] a,
                                input logic [COORD_BITS-1:0] b,
                                input logic [COORD_BITS-1:0] lim);
    logic [COORD_BITS-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff <= lim;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ttd_fsm.sv
// Gesture state machine: event derivation, gesture state and the stored
// touch/tap/lift records. Result is combinational; state moves on step_i.
// Depends on ttd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttd_fsm import ttd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output out_item_t      result_o
);

  mode_e                  mode_q, mode_d;
  logic [LAST_BITS-1:0]   last_q, last_d;
  logic [TIME_BITS-1:0]   touch_t_q, touch_t_d, tap_t_q, tap_t_d;
  logic [TIME_BITS-1:0]   second_t_q, second_t_d, lift_t_q, lift_t_d;
  logic [COORD_BITS-1:0]  touch_x_q, touch_x_d, touch_y_q, touch_y_d;
  logic [COORD_BITS-1:0]  tap_x_q, tap_x_d, tap_y_q, tap_y_d;
  logic [COORD_BITS-1:0]  second_x_q, second_x_d, second_y_q, second_y_d;
  logic                   lifted_q, lifted_d, btn_flag_q, btn_flag_d;

  logic                   present, had_fingers, multi;
  logic [COORD_BITS-1:0]  x, y;
  logic [TIME_BITS-1:0]   now;
  event_e                 ev;
  logic                   btn, rclick, dclick;
  logic                   touch_still, second_still, touch_late, second_late, lock_open;

  assign present     = item_i.finger_present;
  assign x           = item_i.pos_x;
  assign y           = item_i.pos_y;
  assign now         = item_i.time_ms;
  assign had_fingers = (last_q != '0);
  assign multi       = (item_i.finger_total >= TWO_FINGERS);

  // Event from the previous finger count
  always_comb begin
    if (present && !had_fingers) begin
      ev = EV_TOUCH;
    end else if (!present && had_fingers) begin
      ev = EV_RELEASE;
    end else if (present) begin
      ev = ({1'b0, item_i.finger_total} != last_q) ? EV_TOUCH : EV_MOTION;
    end else begin
      ev = EV_TIMEOUT;
    end
  end

  // Shared compares
  assign touch_still  = near(x, touch_x_q, cfg_i.move_limit) &&
                        near(y, touch_y_q, cfg_i.move_limit);
  assign second_still = near(x, second_x_q, cfg_i.move_limit) &&
                        near(y, second_y_q, cfg_i.move_limit);
  assign touch_late   = time_over(now, touch_t_q, cfg_i.tap_limit_ms);
  assign second_late  = time_over(now, second_t_q, cfg_i.tap_limit_ms);
  assign lock_open    = !time_over(now, lift_t_q, cfg_i.drag_lock_window_ms);

  // Next state and result
  always_comb begin
    mode_d     = mode_q;
    last_d     = present ? {1'b0, item_i.finger_total} : '0;
    touch_t_d  = touch_t_q;   touch_x_d  = touch_x_q;   touch_y_d  = touch_y_q;
    tap_t_d    = tap_t_q;     tap_x_d    = tap_x_q;     tap_y_d    = tap_y_q;
    second_t_d = second_t_q;  second_x_d = second_x_q;  second_y_d = second_y_q;
    lift_t_d   = lift_t_q;
    lifted_d   = lifted_q;
    btn_flag_d = btn_flag_q;
    btn        = 1'b0;
    rclick     = 1'b0;
    dclick     = 1'b0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (ev == EV_TOUCH) begin
          touch_t_d = now; touch_x_d = x; touch_y_d = y;
          mode_d = multi ? MODE_TOUCH2 : MODE_TOUCH;
        end
      end
      MODE_TOUCH: begin
        if (ev == EV_RELEASE) begin
          if (!touch_late && touch_still) begin
            btn_flag_d = 1'b1;
            tap_t_d = now; tap_x_d = x; tap_y_d = y;
            mode_d = MODE_FIRST_TAP;
            btn = 1'b1;
          end else begin
            mode_d = MODE_IDLE;
          end
        end else if (ev == EV_MOTION) begin
          if (!touch_still) mode_d = MODE_DEAD;
        end else if (ev == EV_TIMEOUT) begin
          if (touch_late) mode_d = MODE_DEAD;
        end else if (multi) begin
          mode_d = MODE_TOUCH2;
        end
      end
      MODE_TOUCH2: begin
        if (ev == EV_RELEASE) begin
          rclick = !touch_late;
          mode_d = MODE_IDLE;
        end else if (ev == EV_TIMEOUT) begin
          if (touch_late) mode_d = MODE_DEAD;
        end
      end
      MODE_FIRST_TAP: begin
        if (ev == EV_TIMEOUT) begin
          if (btn_flag_q) begin
            btn_flag_d = 1'b0;
          end else if (time_over(now, tap_t_q, cfg_i.double_tap_window_ms)) begin
            mode_d = MODE_IDLE;
          end
        end else if (ev == EV_TOUCH) begin
          if (!time_over(now, tap_t_q, cfg_i.double_tap_window_ms)) begin
            btn_flag_d = 1'b0;
            second_t_d = now; second_x_d = x; second_y_d = y;
            mode_d = MODE_SECOND;
          end else begin
            touch_t_d = now; touch_x_d = x; touch_y_d = y;
            mode_d = MODE_TOUCH;
          end
        end
      end
      MODE_SECOND: begin
        if (ev == EV_RELEASE) begin
          dclick = !second_late && second_still &&
                   near(x, tap_x_q, cfg_i.same_spot_limit) &&
                   near(y, tap_y_q, cfg_i.same_spot_limit);
          mode_d = MODE_IDLE;
        end else if (ev == EV_MOTION) begin
          if (!second_still || second_late) begin
            btn_flag_d = 1'b1;
            lifted_d = 1'b0;
            mode_d = MODE_DRAG;
            btn = 1'b1;
          end
        end else if (ev == EV_TOUCH && multi) begin
          mode_d = MODE_TOUCH2;
        end
      end
      MODE_DRAG: begin
        btn = 1'b1;
        if (ev == EV_RELEASE) begin
          lift_t_d = now;
          lifted_d = 1'b1;
        end else if (ev == EV_TOUCH) begin
          lifted_d = 1'b0;
        end else if (ev == EV_TIMEOUT && lifted_q &&
                     time_over(now, lift_t_q, cfg_i.release_grace_ms)) begin
          if (cfg_i.drag_lock_on) begin
            mode_d = MODE_DRAG_WAIT;
          end else begin
            btn_flag_d = 1'b0;
            mode_d = MODE_IDLE;
            btn = 1'b0;
          end
        end
      end
      MODE_DRAG_WAIT: begin
        btn = 1'b1;
        if (ev == EV_TOUCH && lock_open) begin
          mode_d = MODE_DRAG;
        end else if ((ev == EV_TOUCH || ev == EV_TIMEOUT) && !lock_open) begin
          btn_flag_d = 1'b0;
          mode_d = MODE_IDLE;
          btn = 1'b0;
        end
      end
      MODE_DEAD: begin
        if (ev == EV_RELEASE) mode_d = MODE_IDLE;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  assign result_o = '{button_held: btn, right_click_pulse: rclick,
                      double_click_pulse: dclick};

  // State registers, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      last_q     <= COUNT_UNKNOWN;
      touch_t_q  <= '0; touch_x_q  <= '0; touch_y_q  <= '0;
      tap_t_q    <= '0; tap_x_q    <= '0; tap_y_q    <= '0;
      second_t_q <= '0; second_x_q <= '0; second_y_q <= '0;
      lift_t_q   <= '0;
      lifted_q   <= 1'b0;
      btn_flag_q <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      last_q     <= last_d;
      touch_t_q  <= touch_t_d;  touch_x_q  <= touch_x_d;  touch_y_q  <= touch_y_d;
      tap_t_q    <= tap_t_d;    tap_x_q    <= tap_x_d;    tap_y_q    <= tap_y_d;
      second_t_q <= second_t_d; second_x_q <= second_x_d; second_y_q <= second_y_d;
      lift_t_q   <= lift_t_d;
      lifted_q   <= lifted_d;
      btn_flag_q <= btn_flag_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/touchpad_tap_drag_recognizer.sv
// Top level of the touchpad tap/drag recognizer: input register, config
// registers, gesture state machine and output register.
// Depends on ttd_pkg and ttd_fsm.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------
//   in       | sink      | in_valid_i / in_stall_o   | in_item_i  (in_item_t)
//   out      | source    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//   cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A result is valid after its input transaction passes the input register,
// then the output register; one report per cycle is sustained while the
// output is not stalled, with the gesture step combinational between the two
// registers. Reset clears both stages, the gesture state and loads the register
// defaults. A stalled output holds its result and backs up into the input
// register, which then stalls the input channel.
`timescale 1ns / 1ps
`default_nettype none

module touchpad_tap_drag_recognizer import ttd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire in_item_t                 in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output out_item_t                     out_item_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  cfg_t      cfg_q;
  out_item_t step_result;
  logic      out_free, step;

  // Pipeline control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= step_result;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_limit_ms         <= LIMIT_BITS'(180);
      cfg_q.double_tap_window_ms <= LIMIT_BITS'(300);
      cfg_q.drag_lock_window_ms  <= LIMIT_BITS'(300);
      cfg_q.release_grace_ms     <= LIMIT_BITS'(100);
      cfg_q.move_limit           <= COORD_BITS'(50);
      cfg_q.same_spot_limit      <= COORD_BITS'(100);
      cfg_q.drag_lock_on         <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TAP_LIMIT:  cfg_q.tap_limit_ms         <= cfg_data_i[LIMIT_BITS-1:0];
        REG_DOUBLE_WIN: cfg_q.double_tap_window_ms <= cfg_data_i[LIMIT_BITS-1:0];
        REG_LOCK_WIN:   cfg_q.drag_lock_window_ms  <= cfg_data_i[LIMIT_BITS-1:0];
        REG_DROP_GRACE: cfg_q.release_grace_ms     <= cfg_data_i[LIMIT_BITS-1:0];
        REG_MOVE_LIMIT: cfg_q.move_limit           <= cfg_data_i[COORD_BITS-1:0];
        REG_SPOT_LIMIT: cfg_q.same_spot_limit      <= cfg_data_i[COORD_BITS-1:0];
        REG_LOCK_ON:    cfg_q.drag_lock_on         <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Gesture step
  ttd_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (step_result)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for touchpad_tap_drag_recognizer: directed reports, then
// random gesture sequences under four register settings and three idle mixes.
// Depends on ttd_pkg and the recognizer RTL only.
`timescale 1ns / 1ps

module tb;
  import ttd_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned PHASE_REPORTS = 220;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG = '1;

  // Gesture predictor plus the queue of button results it expects
  class button_scoreboard;
    cfg_t        cfg;
    mode_e       mode;
    logic [3:0]  last_count;
    logic [31:0] touch_time, tap_time, second_time, lift_time;
    logic [15:0] touch_x, touch_y, tap_x, tap_y, second_x, second_y;
    logic        lifted, held;
    out_item_t   expected_buttons[$];
    int unsigned mismatches, checked;
    int unsigned taps, right_clicks, double_clicks, drags, lock_waits;

    function new();
      // register defaults after reset
      cfg.tap_limit_ms         = 16'd180;
      cfg.double_tap_window_ms = 16'd300;
      cfg.drag_lock_window_ms  = 16'd300;
      cfg.release_grace_ms     = 16'd100;
      cfg.move_limit           = 16'd50;
      cfg.same_spot_limit      = 16'd100;
      cfg.drag_lock_on         = 1'b0;
      mode       = MODE_IDLE;
      last_count = COUNT_UNKNOWN;
      touch_time = '0; tap_time = '0; second_time = '0; lift_time = '0;
      touch_x = '0; touch_y = '0; tap_x = '0; tap_y = '0;
      second_x = '0; second_y = '0;
      lifted = 1'b0;
      held   = 1'b0;
    endfunction

    function void load_register(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        REG_TAP_LIMIT:  cfg.tap_limit_ms         = data;
        REG_DOUBLE_WIN: cfg.double_tap_window_ms = data;
        REG_LOCK_WIN:   cfg.drag_lock_window_ms  = data;
        REG_DROP_GRACE: cfg.release_grace_ms     = data;
        REG_MOVE_LIMIT: cfg.move_limit           = data;
        REG_SPOT_LIMIT: cfg.same_spot_limit      = data;
        REG_LOCK_ON:    cfg.drag_lock_on         = data[0];
        default: ;
      endcase
    endfunction

    // wrapping elapsed time strictly beyond a limit
    function bit late(logic [31:0] now_ms, logic [31:0] since_ms, logic [15:0] lim);
      logic [31:0] gap;
      gap = now_ms - since_ms;
      return gap > {16'h0, lim};
    endfunction

    function bit within_reach(logic [15:0] a, logic [15:0] b, logic [15:0] lim);
      logic [15:0] d;
      d = (a > b) ? a - b : b - a;
      return d <= lim;
    endfunction

    function bit steady(logic [15:0] x, logic [15:0] y, logic [15:0] ox, logic [15:0] oy);
      return within_reach(x, ox, cfg.move_limit) && within_reach(y, oy, cfg.move_limit);
    endfunction

    function void start_touch(in_item_t r);
      touch_time = r.time_ms;
      touch_x    = r.pos_x;
      touch_y    = r.pos_y;
    endfunction

    // One report in, one button result queued
    function void predict_report(in_item_t r);
      logic [3:0]  prev;
      logic        had_fingers, in_window;
      logic [31:0] now_ms;
      event_e      ev;
      out_item_t   o;
      o           = '0;
      now_ms      = r.time_ms;
      prev        = last_count;
      had_fingers = (last_count != 4'd0);
      last_count  = r.finger_present ? {1'b0, r.finger_total} : 4'd0;

      if (r.finger_present && !had_fingers) ev = EV_TOUCH;
      else if (!r.finger_present && had_fingers) ev = EV_RELEASE;
      else if (r.finger_present) ev = ({1'b0, r.finger_total} != prev) ? EV_TOUCH : EV_MOTION;
      else ev = EV_TIMEOUT;

      case (mode)
        MODE_IDLE: begin
          if (ev == EV_TOUCH) begin
            start_touch(r);
            mode = (r.finger_total >= TWO_FINGERS) ? MODE_TOUCH2 : MODE_TOUCH;
          end
        end
        MODE_TOUCH: begin
          if (ev == EV_RELEASE) begin
            if (!late(now_ms, touch_time, cfg.tap_limit_ms) &&
                steady(r.pos_x, r.pos_y, touch_x, touch_y)) begin
              held = 1'b1;
              tap_time = now_ms; tap_x = r.pos_x; tap_y = r.pos_y;
              mode = MODE_FIRST_TAP;
              o.button_held = 1'b1;
              taps++;
            end else begin
              mode = MODE_IDLE;
            end
          end else if (ev == EV_MOTION) begin
            if (!steady(r.pos_x, r.pos_y, touch_x, touch_y)) mode = MODE_DEAD;
          end else if (ev == EV_TIMEOUT) begin
            if (late(now_ms, touch_time, cfg.tap_limit_ms)) mode = MODE_DEAD;
          end else if (r.finger_total >= TWO_FINGERS) begin
            mode = MODE_TOUCH2;
          end
        end
        MODE_TOUCH2: begin
          if (ev == EV_RELEASE) begin
            if (!late(now_ms, touch_time, cfg.tap_limit_ms)) begin
              o.right_click_pulse = 1'b1;
              right_clicks++;
            end
            mode = MODE_IDLE;
          end else if (ev == EV_TIMEOUT) begin
            if (late(now_ms, touch_time, cfg.tap_limit_ms)) mode = MODE_DEAD;
          end
        end
        MODE_FIRST_TAP: begin
          if (ev == EV_TIMEOUT) begin
            if (held) held = 1'b0;
            else if (late(now_ms, tap_time, cfg.double_tap_window_ms)) mode = MODE_IDLE;
          end else if (ev == EV_TOUCH) begin
            if (!late(now_ms, tap_time, cfg.double_tap_window_ms)) begin
              held = 1'b0;
              second_time = now_ms; second_x = r.pos_x; second_y = r.pos_y;
              mode = MODE_SECOND;
            end else begin
              start_touch(r);
              mode = MODE_TOUCH;
            end
          end
        end
        MODE_SECOND: begin
          if (ev == EV_RELEASE) begin
            if (!late(now_ms, second_time, cfg.tap_limit_ms) &&
                steady(r.pos_x, r.pos_y, second_x, second_y) &&
                within_reach(r.pos_x, tap_x, cfg.same_spot_limit) &&
                within_reach(r.pos_y, tap_y, cfg.same_spot_limit)) begin
              o.double_click_pulse = 1'b1;
              double_clicks++;
            end
            mode = MODE_IDLE;
          end else if (ev == EV_MOTION) begin
            if (!steady(r.pos_x, r.pos_y, second_x, second_y) ||
                late(now_ms, second_time, cfg.tap_limit_ms)) begin
              held   = 1'b1;
              lifted = 1'b0;
              mode   = MODE_DRAG;
              o.button_held = 1'b1;
              drags++;
            end
          end else if (ev == EV_TOUCH && r.finger_total >= TWO_FINGERS) begin
            mode = MODE_TOUCH2;
          end
        end
        MODE_DRAG: begin
          o.button_held = 1'b1;
          if (ev == EV_RELEASE) begin
            lift_time = now_ms;
            lifted    = 1'b1;
          end else if (ev == EV_TOUCH) begin
            lifted = 1'b0;
          end else if (ev == EV_TIMEOUT && lifted &&
                       late(now_ms, lift_time, cfg.release_grace_ms)) begin
            if (cfg.drag_lock_on) begin
              mode = MODE_DRAG_WAIT;
              lock_waits++;
            end else begin
              held = 1'b0;
              mode = MODE_IDLE;
              o.button_held = 1'b0;
            end
          end
        end
        MODE_DRAG_WAIT: begin
          o.button_held = 1'b1;
          if (ev == EV_TOUCH || ev == EV_TIMEOUT) begin
            in_window = !late(now_ms, lift_time, cfg.drag_lock_window_ms);
            if (ev == EV_TOUCH && in_window) begin
              mode = MODE_DRAG;
            end else if (!in_window) begin
              held = 1'b0;
              mode = MODE_IDLE;
              o.button_held = 1'b0;
            end
          end
        end
        default: begin
          // dead gesture waits for the fingers to lift
          if (ev == EV_RELEASE) mode = MODE_IDLE;
        end
      endcase
      expected_buttons.push_back(o);
    endfunction

    function void check_buttons(out_item_t got);
      out_item_t want;
      if (expected_buttons.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        return;
      end
      want = expected_buttons.pop_front();
      if (got.button_held !== want.button_held) begin
        mismatches++;
        $display("%0t: button_held expected %b actual %b", $time,
                 want.button_held, got.button_held);
      end
      if (got.right_click_pulse !== want.right_click_pulse) begin
        mismatches++;
        $display("%0t: right_click_pulse expected %b actual %b", $time,
                 want.right_click_pulse, got.right_click_pulse);
      end
      if (got.double_click_pulse !== want.double_click_pulse) begin
        mismatches++;
        $display("%0t: double_click_pulse expected %b actual %b", $time,
                 want.double_click_pulse, got.double_click_pulse);
      end
      checked++;
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  in_item_t                 in_item_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  out_item_t                out_item_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  button_scoreboard sb = new();

  logic [31:0] clock_ms;
  logic [15:0] px, py;
  logic [15:0] reg_words [2**CFG_IDX_BITS];
  int unsigned sent_reports, cfg_writes;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct, recv_idle_pct;
  logic        hold_go, hold_done;

  touchpad_tap_drag_recognizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stall, plus one long hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_buttons(out_item_o);
  end

  // Watchdog: any channel moving counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one report and hold it until accepted
  task automatic report_at(input logic present, input logic [2:0] cnt,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] t);
    in_item_t r;
    r.finger_present = present;
    r.finger_total   = cnt;
    r.pos_x          = x;
    r.pos_y          = y;
    r.time_ms        = t;
    clock_ms         = t;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_report(r);
    sent_reports++;
  endtask

  task automatic emit(input logic present, input logic [2:0] cnt,
                      input logic [15:0] x, input logic [15:0] y, input logic [31:0] dt);
    report_at(present, cnt, x, y, clock_ms + dt);
  endtask

  // Write every register index (spare one included), then drop valid
  task automatic program_registers();
    for (int i = 0; i < 2**CFG_IDX_BITS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_BITS'(i);
      cfg_data_i  <= reg_words[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.load_register(CFG_IDX_BITS'(i), reg_words[i]);
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_outputs();
    while (sb.expected_buttons.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Delays and offsets cluster around a limit to hit both sides of it
  function automatic logic [31:0] pick_delay(input logic [15:0] lim);
    case ($urandom_range(6))
      0:       return '0;
      1:       return 32'(lim);
      2:       return 32'(lim) + 1;
      3:       return (lim == 0) ? '0 : 32'(lim) - 1;
      4:       return $urandom_range(lim);
      5:       return $urandom_range(32'(lim) * 2 + 10);
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic logic [15:0] pick_offset(input logic [15:0] lim);
    case ($urandom_range(5))
      0:       return '0;
      1:       return lim;
      2:       return (lim == 16'hFFFF) ? lim : lim + 16'd1;
      3:       return (lim == 0) ? lim : lim - 16'd1;
      4:       return 16'($urandom_range(lim));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] nudge(input logic [15:0] base, input logic [15:0] d);
    if ($urandom_range(1) && base >= d) return base - d;
    if (17'(base) + 17'(d) <= 17'h0FFFF) return base + d;
    if (base >= d) return base - d;
    return base;
  endfunction

  // touch at the current spot, then the given motions and a lift, offset around the move limit
  task automatic stroke(input logic [2:0] cnt, input int unsigned moves);
    emit(1'b1, cnt, px, py, pick_delay(sb.cfg.double_tap_window_ms));
    repeat (moves)
      emit(1'b1, cnt, nudge(px, pick_offset(sb.cfg.move_limit)),
           nudge(py, pick_offset(sb.cfg.move_limit)), pick_delay(sb.cfg.tap_limit_ms >> 1));
    emit(1'b0, 3'($urandom()), nudge(px, pick_offset(sb.cfg.move_limit)),
         nudge(py, pick_offset(sb.cfg.move_limit)), pick_delay(sb.cfg.tap_limit_ms));
  endtask

  task automatic idle_reports(input int unsigned n, input logic [15:0] lim);
    repeat (n) emit(1'b0, 3'($urandom()), 16'($urandom()), 16'($urandom()), pick_delay(lim));
  endtask

  task automatic drag_gesture();
    stroke(3'd1, 0);
    emit(1'b1, 3'd1, px, py, pick_delay(sb.cfg.double_tap_window_ms));
    repeat ($urandom_range(4, 1)) begin
      px = nudge(px, pick_offset(sb.cfg.move_limit));
      py = nudge(py, pick_offset(sb.cfg.move_limit));
      emit(1'b1, 3'd1, px, py, pick_delay(sb.cfg.tap_limit_ms));
    end
    emit(1'b0, 3'($urandom()), px, py, pick_delay(sb.cfg.tap_limit_ms));
    idle_reports($urandom_range(2), sb.cfg.release_grace_ms);
    if ($urandom_range(1)) begin
      // pick the drag up again, possibly out of drag-lock wait
      emit(1'b1, 3'd1, px, py, pick_delay(sb.cfg.drag_lock_window_ms));
      emit(1'b1, 3'd1, nudge(px, pick_offset(sb.cfg.move_limit)), py,
           pick_delay(sb.cfg.tap_limit_ms));
      emit(1'b0, 3'($urandom()), px, py, pick_delay(sb.cfg.release_grace_ms));
    end
    idle_reports($urandom_range(3, 1), sb.cfg.drag_lock_window_ms);
  endtask

  task automatic play_gesture();
    px = 16'($urandom());
    py = 16'($urandom());
    case ($urandom_range(11))
      0, 1: begin
        // single tap, sometimes left to expire
        stroke(3'd1, $urandom_range(2));
        idle_reports($urandom_range(3), sb.cfg.double_tap_window_ms);
      end
      2: begin
        stroke(3'($urandom_range(7, 2)), $urandom_range(1));
        idle_reports($urandom_range(2), sb.cfg.tap_limit_ms);
      end
      3, 4: begin
        // double tap, second one near the first spot
        stroke(3'd1, $urandom_range(1));
        idle_reports($urandom_range(1), sb.cfg.double_tap_window_ms);
        px = nudge(px, pick_offset(sb.cfg.same_spot_limit));
        py = nudge(py, pick_offset(sb.cfg.same_spot_limit));
        stroke(3'd1, $urandom_range(1));
        idle_reports($urandom_range(2), sb.cfg.double_tap_window_ms);
      end
      5, 6, 7: drag_gesture();
      8: begin
        // one finger grows into several
        emit(1'b1, 3'd1, px, py, pick_delay(sb.cfg.double_tap_window_ms));
        stroke(3'($urandom_range(7, 2)), 0);
      end
      9: begin
        // tap, then the second touch adds fingers
        stroke(3'd1, 0);
        emit(1'b1, 3'd1, px, py, pick_delay(sb.cfg.double_tap_window_ms));
        stroke(3'($urandom_range(7, 2)), $urandom_range(1));
      end
      10: begin
        // zero-finger reports make later empty reports time out mid-gesture
        emit(1'b1, 3'($urandom_range(2)), px, py, pick_delay(sb.cfg.tap_limit_ms));
        emit(1'b1, 3'd0, px, py, pick_delay(sb.cfg.tap_limit_ms));
        idle_reports($urandom_range(3, 1), sb.cfg.tap_limit_ms);
      end
      default: begin
        repeat ($urandom_range(4, 1))
          emit(1'($urandom()), 3'($urandom()), 16'($urandom()), 16'($urandom()),
               $urandom_range(1) ? $urandom() : 32'($urandom_range(500)));
      end
    endcase
  endtask

  // Hand-picked reports under the reset register values
  task automatic run_directed();
    report_at(1'b0, 3'd0, 16'd0, 16'd0, 32'd1000);        // unknown count: release
    report_at(1'b0, 3'd5, 16'd0, 16'd0, 32'd1010);        // nothing before or now
    report_at(1'b1, 3'd0, 16'd1000, 16'd1000, 32'd1020);  // present, zero fingers
    report_at(1'b1, 3'd1, 16'd1000, 16'd1000, 32'd1030);
    report_at(1'b1, 3'd1, 16'd1010, 16'd1010, 32'd1040);
    report_at(1'b0, 3'd0, 16'd1020, 16'd1020, 32'd1100);  // tap
    report_at(1'b0, 3'd0, 16'd1020, 16'd1020, 32'd1150);
    report_at(1'b1, 3'd1, 16'd1020, 16'd1020, 32'd1200);  // second touch
    report_at(1'b1, 3'd1, 16'd1300, 16'd1020, 32'd1210);  // drag starts
    report_at(1'b1, 3'd1, 16'd1400, 16'd1020, 32'd1260);
    report_at(1'b0, 3'd0, 16'd1400, 16'd1020, 32'd1300);  // lift
    report_at(1'b0, 3'd0, 16'd1400, 16'd1020, 32'd1350);  // inside drop grace
    report_at(1'b0, 3'd0, 16'd1400, 16'd1020, 32'd1450);  // drop
    report_at(1'b1, 3'd1, 16'd40000, 16'd40000, 32'd2000);
    report_at(1'b0, 3'd0, 16'd40000, 16'd40000, 32'd2050);
    report_at(1'b1, 3'd1, 16'd40030, 16'd39970, 32'd2100);
    report_at(1'b0, 3'd0, 16'd40030, 16'd39970, 32'd2150); // double click
    report_at(1'b1, 3'd2, 16'd500, 16'd500, 32'd3000);
    report_at(1'b0, 3'd0, 16'd500, 16'd500, 32'd3100);     // right click
    report_at(1'b1, 3'd7, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0);
    report_at(1'b0, 3'd0, 16'hFFFF, 16'h0000, 32'h0000_0010); // across the wrap
    report_at(1'b1, 3'd1, 16'h0000, 16'hFFFF, 32'h0000_0020);
    report_at(1'b1, 3'd1, 16'hFFFF, 16'hFFFF, 32'h0000_0030); // moved too far
    report_at(1'b0, 3'd7, 16'hFFFF, 16'hFFFF, 32'h0000_0040);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_go       = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_reports  = 0;
    cfg_writes    = 0;
    clock_ms      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle_outputs();

    for (int phase = 0; phase < 4; phase++) begin
      foreach (reg_words[i]) reg_words[i] = 16'($urandom());
      case (phase)
        1: begin
          reg_words[REG_TAP_LIMIT]  = 16'hFFFF;
          reg_words[REG_DOUBLE_WIN] = 16'hFFFF;
          reg_words[REG_LOCK_WIN]   = 16'hFFFF;
          reg_words[REG_DROP_GRACE] = 16'hFFFF;
          reg_words[REG_MOVE_LIMIT] = 16'h0000;
          reg_words[REG_SPOT_LIMIT] = 16'h0000;
          reg_words[REG_LOCK_ON]    = 16'hFFFF;  // upper bits masked off
        end
        2: begin
          reg_words[REG_TAP_LIMIT]  = 16'h0000;
          reg_words[REG_DOUBLE_WIN] = 16'h0000;
          reg_words[REG_LOCK_WIN]   = 16'h0000;
          reg_words[REG_DROP_GRACE] = 16'h0000;
          reg_words[REG_MOVE_LIMIT] = 16'hFFFF;
          reg_words[REG_SPOT_LIMIT] = 16'hFFFF;
          reg_words[REG_LOCK_ON]    = 16'hFFFE;
        end
        default: begin
          // realistic touchpad timing and distances
          reg_words[REG_TAP_LIMIT]  = 16'($urandom_range(400, 20));
          reg_words[REG_DOUBLE_WIN] = 16'($urandom_range(600, 50));
          reg_words[REG_LOCK_WIN]   = 16'($urandom_range(600, 50));
          reg_words[REG_DROP_GRACE] = 16'($urandom_range(300, 20));
          reg_words[REG_MOVE_LIMIT] = 16'($urandom_range(200));
          reg_words[REG_SPOT_LIMIT] = 16'($urandom_range(300));
          if (phase == 0) reg_words[REG_LOCK_ON] = 16'h0001;
        end
      endcase
      reg_words[SPARE_REG] = 16'($urandom());
      program_registers();

      case (phase)
        0: begin send_idle_pct = 8;  recv_idle_pct <= 67; end
        1: begin send_idle_pct = 67; recv_idle_pct <= 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      if (phase == 2) hold_go <= 1'b1;
      clock_ms = (phase == 0) ? 32'hFFFF_F000 : $urandom();

      target = sent_reports + PHASE_REPORTS;
      while (sent_reports < target) play_gesture();
      in_valid_i <= 1'b0;
      settle_outputs();
    end

    repeat (10) @(posedge clk_i);
    $display("tb: %0d reports, %0d register writes, %0d results checked, 4 random settings",
             sent_reports, cfg_writes, sb.checked);
    $display("tb: seen %0d taps, %0d right clicks, %0d double clicks, %0d drags, %0d lock waits",
             sb.taps, sb.right_clicks, sb.double_clicks, sb.drags, sb.lock_waits);
    if (sb.expected_buttons.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_buttons.size());
    if (sb.mismatches == 0 && sb.expected_buttons.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ttd_pkg.sv
hdl/ttd_fsm.sv
hdl/touchpad_tap_drag_recognizer.sv
bench/tb.sv
